// ===== rtl/core/pcse_pkg.sv =====
// shared types, codes and helper functions for the pulse channel
package pcse_pkg;

  localparam logic [2:0] OP_WRITE     = 3'd0;
  localparam logic [2:0] OP_READ      = 3'd1;
  localparam logic [2:0] OP_DIV_TICK  = 3'd2;
  localparam logic [2:0] OP_ENV_TICK  = 3'd3;
  localparam logic [2:0] OP_LEN_TICK  = 3'd4;
  localparam logic [2:0] OP_SWP_TICK  = 3'd5;

  localparam logic [2:0] REG_SWEEP    = 3'd0;
  localparam logic [2:0] REG_LEN_DUTY = 3'd1;
  localparam logic [2:0] REG_ENVELOPE = 3'd2;
  localparam logic [2:0] REG_PER_LOW  = 3'd3;
  localparam logic [2:0] REG_PER_HIGH = 3'd4;

  localparam logic [10:0] PERIOD_MAX    = 11'h7FF;
  localparam logic [6:0]  LENGTH_FULL   = 7'd64;
  localparam logic [3:0]  SWEEP_DEFAULT = 4'd8;
  localparam logic [7:0]  LEN_READ_MASK = 8'hC0;
  localparam logic [7:0]  HI_READ_MASK  = 8'h40;
  localparam logic [7:0]  LOW_READ_VAL  = 8'hFF;
  localparam logic [2:0]  DIV_LAST_STEP = 3'd7;

  localparam logic [3:0][7:0] DUTY_TABLE = {8'h7E, 8'hE1, 8'h81, 8'h80};

  typedef struct packed {
    logic latch;
    logic exec;
    logic div_step;
    logic sweep2;
    logic load_out;
  } pcse_cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_sweep2;
    logic div_last;
  } pcse_stat_t;

  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] step);
    return DUTY_TABLE[duty][~step];
  endfunction

  function automatic logic [11:0] sweep_calc(input logic [10:0] period,
                                             input logic [2:0]  shift,
                                             input logic        neg);
    logic [10:0] delta;
    delta = period >> shift;
    if (neg) begin
      return {1'b0, period} - {1'b0, delta};
    end
    return {1'b0, period} + {1'b0, delta};
  endfunction

endpackage

// ===== rtl/core/pcse_req_if.sv =====
// event channel carrying opcode, register index and write byte
interface pcse_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [2:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, opcode, reg_index, write_data, input ready);
  modport sink   (input valid, opcode, reg_index, write_data, output ready);
endinterface

// ===== rtl/core/pcse_rsp_if.sv =====
// result channel carrying read data and channel status
interface pcse_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       wave_bit;
  logic [3:0] volume_level;
  logic       channel_active;

  modport source (output valid, read_data, wave_bit, volume_level, channel_active,
                  input ready);
  modport sink   (input valid, read_data, wave_bit, volume_level, channel_active,
                  output ready);
endinterface

// ===== rtl/core/pcse_datapath.sv =====
// channel registers, timers, sweep unit, remainder unit and result register
module pcse_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_data,
  input  logic [2:0]            opcode,
  input  logic [2:0]            reg_index,
  input  logic [7:0]            write_data,
  input  pcse_pkg::pcse_cmd_t   cmd,
  output pcse_pkg::pcse_stat_t  stat,
  output logic [7:0]            read_data,
  output logic                  wave_bit,
  output logic [3:0]            volume_level,
  output logic                  channel_active
);

  logic        sweep_present;
  logic [7:0]  sweep_setting;
  logic [7:0]  length_duty_setting;
  logic [7:0]  envelope_setting;
  logic [7:0]  period_low_byte;
  logic [7:0]  period_high_ctrl;
  logic [10:0] period_count;
  logic [2:0]  duty_step;
  logic        wave_out;
  logic [3:0]  cur_volume;
  logic [7:0]  env_count;
  logic        sweep_on;
  logic [3:0]  sweep_count;
  logic [10:0] shadow_period;
  logic [6:0]  length_count;
  logic        sweep_disabled;
  logic        length_on;
  logic [2:0]  sweep_period_latched;

  logic [2:0]  op;
  logic [2:0]  ri;
  logic [7:0]  wd;

  logic [2:0]  div_rem;
  logic [7:0]  div_dvd;
  logic [2:0]  div_cnt;

  logic [2:0]  sw_shift;
  logic        sw_neg;
  logic [2:0]  sw_pace;
  logic [2:0]  env_pace;
  logic        dac_on;
  logic        trigger;
  logic [10:0] trig_period;
  logic [10:0] calc_in;
  logic [11:0] calc_out;
  logic [3:0]  sc_dec;
  logic [3:0]  div_trial;
  logic [3:0]  div_rem_next;
  logic [2:0]  duty_step_next;
  logic        active;
  logic [7:0]  rd_value;

  always_comb begin
    sw_shift       = sweep_setting[2:0];
    sw_neg         = sweep_setting[3];
    sw_pace        = sweep_setting[6:4];
    env_pace       = envelope_setting[2:0];
    dac_on         = |envelope_setting[7:3];
    trigger        = wd[7] && dac_on;
    trig_period    = {wd[2:0], period_low_byte};
    calc_in        = (op == pcse_pkg::OP_WRITE) ? trig_period : shadow_period;
    calc_out       = pcse_pkg::sweep_calc(calc_in, sw_shift, sw_neg);
    sc_dec         = (sweep_count != 4'd0) ? sweep_count - 4'd1 : sweep_count;
    div_trial      = {div_rem, div_dvd[7]};
    div_rem_next   = (div_trial >= {1'b0, env_pace}) ? div_trial - {1'b0, env_pace}
                                                     : div_trial;
    duty_step_next = duty_step + 3'd1;
    active         = dac_on && !sweep_disabled && (!length_on || length_count != 7'd0);

    stat.need_div    = (op == pcse_pkg::OP_ENV_TICK) && (env_pace != 3'd0);
    stat.need_sweep2 = (op == pcse_pkg::OP_SWP_TICK) && sweep_present && (sc_dec == 4'd0)
                       && sweep_on && (sweep_period_latched != 3'd0);
    stat.div_last    = (div_cnt == pcse_pkg::DIV_LAST_STEP);

    rd_value = 8'd0;
    if (op == pcse_pkg::OP_READ) begin
      unique case (ri)
        pcse_pkg::REG_SWEEP:    rd_value = sweep_present ? sweep_setting : 8'd0;
        pcse_pkg::REG_LEN_DUTY: rd_value = length_duty_setting & pcse_pkg::LEN_READ_MASK;
        pcse_pkg::REG_ENVELOPE: rd_value = envelope_setting;
        pcse_pkg::REG_PER_LOW:  rd_value = pcse_pkg::LOW_READ_VAL;
        pcse_pkg::REG_PER_HIGH: rd_value = period_high_ctrl & pcse_pkg::HI_READ_MASK;
        default:                rd_value = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op <= opcode;
      ri <= reg_index;
      wd <= write_data;
    end
    if (cmd.load_out) begin
      read_data      <= rd_value;
      wave_bit       <= active && wave_out;
      volume_level   <= cur_volume;
      channel_active <= active;
    end
    if (cmd.exec) begin
      div_rem <= 3'd0;
      div_dvd <= env_count + 8'd1;
      div_cnt <= 3'd0;
    end else if (cmd.div_step) begin
      div_rem <= div_rem_next[2:0];
      div_dvd <= {div_dvd[6:0], 1'b0};
      div_cnt <= div_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_present        <= 1'b1;
      sweep_setting        <= '0;
      length_duty_setting  <= '0;
      envelope_setting     <= '0;
      period_low_byte      <= '0;
      period_high_ctrl     <= '0;
      period_count         <= '0;
      duty_step            <= '0;
      wave_out             <= 1'b0;
      cur_volume           <= '0;
      env_count            <= '0;
      sweep_on             <= 1'b0;
      sweep_count          <= '0;
      shadow_period        <= '0;
      length_count         <= '0;
      sweep_disabled       <= 1'b0;
      length_on            <= 1'b0;
      sweep_period_latched <= '0;
    end else begin
      if (cfg_we) begin
        sweep_present <= cfg_data;
      end
      if (cmd.exec) begin
        unique case (op)
          pcse_pkg::OP_WRITE: begin
            unique case (ri)
              pcse_pkg::REG_SWEEP: begin
                if (sweep_present) begin
                  sweep_setting <= wd;
                end
              end
              pcse_pkg::REG_LEN_DUTY: begin
                length_duty_setting <= wd;
                length_count        <= pcse_pkg::LENGTH_FULL - {1'b0, wd[5:0]};
              end
              pcse_pkg::REG_ENVELOPE: envelope_setting <= wd;
              pcse_pkg::REG_PER_LOW:  period_low_byte  <= wd;
              pcse_pkg::REG_PER_HIGH: begin
                period_high_ctrl <= wd;
                sweep_disabled   <= trigger && sweep_present && (sw_shift != 3'd0)
                                    && calc_out[11];
                length_on        <= wd[6];
                if (trigger) begin
                  if (length_count == 7'd0) begin
                    length_count <= pcse_pkg::LENGTH_FULL
                                    - {1'b0, length_duty_setting[5:0]};
                  end
                  env_count    <= '0;
                  period_count <= trig_period;
                  cur_volume   <= envelope_setting[7:4];
                  if (sweep_present) begin
                    shadow_period        <= trig_period;
                    sweep_count          <= (sw_pace != 3'd0) ? {1'b0, sw_pace}
                                                              : pcse_pkg::SWEEP_DEFAULT;
                    sweep_period_latched <= sw_pace;
                    sweep_on             <= (sw_pace != 3'd0) || (sw_shift != 3'd0);
                  end
                end
              end
              default: ;
            endcase
          end
          pcse_pkg::OP_DIV_TICK: begin
            if (period_count == pcse_pkg::PERIOD_MAX) begin
              period_count <= {period_high_ctrl[2:0], period_low_byte};
              duty_step    <= duty_step_next;
              wave_out     <= pcse_pkg::duty_bit(length_duty_setting[7:6], duty_step_next);
            end else begin
              period_count <= period_count + 11'd1;
            end
          end
          pcse_pkg::OP_ENV_TICK: env_count <= env_count + 8'd1;
          pcse_pkg::OP_LEN_TICK: begin
            if (length_count != 7'd0) begin
              length_count <= length_count - 7'd1;
            end
          end
          pcse_pkg::OP_SWP_TICK: begin
            if (sweep_present) begin
              if (sc_dec == 4'd0) begin
                sweep_count <= (sweep_period_latched != 3'd0)
                               ? {1'b0, sweep_period_latched} : pcse_pkg::SWEEP_DEFAULT;
                if (sweep_on && sweep_period_latched != 3'd0) begin
                  if (calc_out[11]) begin
                    sweep_disabled <= 1'b1;
                  end else if (sw_shift != 3'd0) begin
                    period_count     <= calc_out[10:0];
                    shadow_period    <= calc_out[10:0];
                    period_low_byte  <= calc_out[7:0];
                    period_high_ctrl <= {period_high_ctrl[7:3], calc_out[10:8]};
                  end
                  sweep_period_latched <= sw_pace;
                end
              end else begin
                sweep_count <= sc_dec;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.div_step && stat.div_last && div_rem_next == 4'd0) begin
        if (envelope_setting[3]) begin
          if (cur_volume != 4'd15) begin
            cur_volume <= cur_volume + 4'd1;
          end
        end else if (cur_volume != 4'd0) begin
          cur_volume <= cur_volume - 4'd1;
        end
      end
      if (cmd.sweep2 && calc_out[11]) begin
        sweep_disabled <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/pcse_controller.sv =====
// sequencing state machine and result valid flag
module pcse_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  pcse_pkg::pcse_stat_t  stat,
  output pcse_pkg::pcse_cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_DONE  = 5'b10000
  } pcse_state_t;

  pcse_state_t state;
  pcse_state_t state_next;
  logic        rsp_valid_next;

  always_comb begin
    req_ready      = (state == ST_IDLE);
    cmd            = '0;
    cmd.latch      = req_valid && req_ready;
    state_next     = state;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        priority if (stat.need_div) begin
          state_next = ST_DIV;
        end else if (stat.need_sweep2) begin
          state_next = ST_SWEEP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep2 = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ===== rtl/core/pulse_channel_sweep_envelope_top.sv =====
// top level of the square-wave channel with sweep, envelope and length
//
//   channel | dir | payload                                         | handshake
//   req     | in  | opcode, reg_index, write_data                   | valid/ready
//   rsp     | out | read_data, wave_bit, volume_level, channel_active | valid/ready
//   cfg     | in  | cfg_data (sweep_present)                        | cfg_we
//
// one event at a time: the next event is accepted only once the last one is done
// a sweep tick that runs the sweep step also passes through the sweep state (second target check)
// an envelope tick with nonzero pace also passes through the div state (8-step remainder unit)
// the result register lets a new event enter while the last result waits
// rst is synchronous; sweep_present resets to 1, all channel state to 0
module pulse_channel_sweep_envelope_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  pcse_req_if.sink    req,
  pcse_rsp_if.source  rsp
);

  pcse_pkg::pcse_cmd_t  cmd;
  pcse_pkg::pcse_stat_t stat;

  pcse_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcse_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .opcode         (req.opcode),
    .reg_index      (req.reg_index),
    .write_data     (req.write_data),
    .cmd            (cmd),
    .stat           (stat),
    .read_data      (rsp.read_data),
    .wave_bit       (rsp.wave_bit),
    .volume_level   (rsp.volume_level),
    .channel_active (rsp.channel_active)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("event accepted while previous one still in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> !$past(req.ready))
    else $error("result raised without an event in work");

  a_inactive_silent: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.channel_active |-> !rsp.wave_bit)
    else $error("wave bit high on inactive channel");

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the pulse channel: predicts each event's status and checks the result stream
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE6  = 3'd6;
  localparam logic [2:0] OP_SPARE7  = 3'd7;
  localparam logic [2:0] REG_SPARE5 = 3'd5;
  localparam logic [2:0] REG_SPARE7 = 3'd7;

  localparam int ITEMS_PER_PHASE = 617;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 20;

  typedef struct packed {
    logic [7:0] read_data;
    logic       wave_bit;
    logic [3:0] volume_level;
    logic       channel_active;
  } chan_status_t;

  typedef struct packed {
    logic [2:0]   op;
    logic [2:0]   ri;
    logic [7:0]   wd;
    logic         typed;
    chan_status_t want;
  } dir_row_t;

  localparam chan_status_t ALL_ZERO = '0;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_data;

  pcse_req_if req_bus ();
  pcse_rsp_if rsp_bus ();

  pulse_channel_sweep_envelope_top uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_bus),
    .rsp      (rsp_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // channel model state
  logic        sweep_fitted;
  logic [7:0]  sweep_reg, len_duty_reg, env_reg, per_low_reg, per_high_reg;
  logic [10:0] div_count;
  logic [2:0]  duty_pos;
  logic        wave_level;
  logic [3:0]  volume;
  logic [7:0]  env_ticks;
  logic        sweep_armed;
  logic [3:0]  sweep_countdown;
  logic [10:0] shadow_freq;
  logic [6:0]  length_left;
  logic        sweep_overflow;
  logic        len_gate_on;
  logic [2:0]  sweep_pace_held;

  chan_status_t expected_status[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 30;
  int           recv_idle_pct = 30;
  int           phase_num = -1;
  dir_row_t     directed_rows [26];

  function automatic logic [10:0] period_regs();
    return {per_high_reg[2:0], per_low_reg};
  endfunction

  function automatic logic [11:0] next_sweep_freq();
    logic [11:0] nf;
    if (sweep_reg[3]) begin
      nf = {1'b0, shadow_freq} - {1'b0, shadow_freq >> sweep_reg[2:0]};
    end else begin
      nf = {1'b0, shadow_freq} + {1'b0, shadow_freq >> sweep_reg[2:0]};
    end
    if (nf > 12'h7FF) sweep_overflow = 1'b1;
    return nf;
  endfunction

  function automatic chan_status_t apply_event(input logic [2:0] op, input logic [2:0] ri,
                                               input logic [7:0] wd);
    chan_status_t st;
    logic [2:0]   pace;
    logic [11:0]  nf;
    logic [7:0]   pattern;
    logic         live;
    st = '0;
    case (op)
      pcse_pkg::OP_WRITE: begin
        case (ri)
          pcse_pkg::REG_SWEEP: if (sweep_fitted) sweep_reg = wd;
          pcse_pkg::REG_LEN_DUTY: begin
            len_duty_reg = wd;
            length_left = pcse_pkg::LENGTH_FULL - {1'b0, wd[5:0]};
          end
          pcse_pkg::REG_ENVELOPE: env_reg = wd;
          pcse_pkg::REG_PER_LOW: per_low_reg = wd;
          pcse_pkg::REG_PER_HIGH: begin
            per_high_reg = wd;
            sweep_overflow = 1'b0;
            len_gate_on = wd[6];
            if (wd[7] && env_reg[7:3] != 5'd0) begin
              pace = sweep_reg[6:4];
              if (length_left == 7'd0) begin
                length_left = pcse_pkg::LENGTH_FULL - {1'b0, len_duty_reg[5:0]};
              end
              env_ticks = 8'd0;
              div_count = period_regs();
              volume = env_reg[7:4];
              if (sweep_fitted) begin
                shadow_freq = div_count;
                sweep_countdown = (pace != 3'd0) ? {1'b0, pace} : pcse_pkg::SWEEP_DEFAULT;
                sweep_pace_held = pace;
                sweep_armed = (pace != 3'd0) || (sweep_reg[2:0] != 3'd0);
                if (sweep_reg[2:0] != 3'd0) nf = next_sweep_freq();
              end
            end
          end
          default: ;
        endcase
      end
      pcse_pkg::OP_READ: begin
        case (ri)
          pcse_pkg::REG_SWEEP:    st.read_data = sweep_fitted ? sweep_reg : 8'h00;
          pcse_pkg::REG_LEN_DUTY: st.read_data = len_duty_reg & pcse_pkg::LEN_READ_MASK;
          pcse_pkg::REG_ENVELOPE: st.read_data = env_reg;
          pcse_pkg::REG_PER_LOW:  st.read_data = pcse_pkg::LOW_READ_VAL;
          pcse_pkg::REG_PER_HIGH: st.read_data = per_high_reg & pcse_pkg::HI_READ_MASK;
          default:                st.read_data = 8'h00;
        endcase
      end
      pcse_pkg::OP_DIV_TICK: begin
        if (div_count == pcse_pkg::PERIOD_MAX) begin
          div_count = period_regs();
          duty_pos = duty_pos + 3'd1;
          case (len_duty_reg[7:6])
            2'd0: pattern = 8'h80;
            2'd1: pattern = 8'h81;
            2'd2: pattern = 8'hE1;
            default: pattern = 8'h7E;
          endcase
          wave_level = pattern[3'd7 - duty_pos];
        end else begin
          div_count = div_count + 11'd1;
        end
      end
      pcse_pkg::OP_ENV_TICK: begin
        env_ticks = env_ticks + 8'd1;
        if (env_reg[2:0] != 3'd0 && (env_ticks % env_reg[2:0]) == 8'd0) begin
          if (env_reg[3]) begin
            if (volume != 4'd15) volume = volume + 4'd1;
          end else begin
            if (volume != 4'd0) volume = volume - 4'd1;
          end
        end
      end
      pcse_pkg::OP_LEN_TICK: begin
        if (length_left != 7'd0) length_left = length_left - 7'd1;
      end
      pcse_pkg::OP_SWP_TICK: begin
        if (sweep_fitted) begin
          if (sweep_countdown != 4'd0) sweep_countdown = sweep_countdown - 4'd1;
          if (sweep_countdown == 4'd0) begin
            sweep_countdown = (sweep_pace_held != 3'd0) ? {1'b0, sweep_pace_held}
                                                        : pcse_pkg::SWEEP_DEFAULT;
            if (sweep_armed && sweep_pace_held != 3'd0) begin
              nf = next_sweep_freq();
              if (sweep_reg[2:0] != 3'd0 && nf <= 12'h7FF) begin
                div_count = nf[10:0];
                shadow_freq = nf[10:0];
                per_low_reg = nf[7:0];
                per_high_reg = {per_high_reg[7:3], nf[10:8]};
              end
              sweep_pace_held = sweep_reg[6:4];
              nf = next_sweep_freq();
            end
          end
        end
      end
      default: ;
    endcase
    live = (env_reg[7:3] != 5'd0) && !sweep_overflow
           && (!len_gate_on || length_left != 7'd0);
    st.wave_bit = live & wave_level;
    st.volume_level = volume;
    st.channel_active = live;
    return st;
  endfunction

  task automatic flag_mismatch(input chan_status_t want, input chan_status_t got,
                               input bit orphan);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (orphan) begin
        $display("unexpected result: rd=%h wave=%b vol=%0d act=%b",
                 got.read_data, got.wave_bit, got.volume_level, got.channel_active);
      end else begin
        $display({"mismatch: expected rd=%h wave=%b vol=%0d act=%b,",
                  " got rd=%h wave=%b vol=%0d act=%b"},
                 want.read_data, want.wave_bit, want.volume_level, want.channel_active,
                 got.read_data, got.wave_bit, got.volume_level, got.channel_active);
      end
    end
  endtask

  task automatic send_event(input logic [2:0] op, input logic [2:0] ri, input logic [7:0] wd,
                            input logic typed, input chan_status_t want);
    chan_status_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.opcode     <= op;
    req_bus.reg_index  <= ri;
    req_bus.write_data <= wd;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    pred = apply_event(op, ri, wd);
    expected_status.push_back(typed ? want : pred);
  endtask

  task automatic write_sweep_present(input logic value);
    req_bus.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sweep_fitted = value;
  endtask

  // result checker and receiver stalls
  initial begin
    chan_status_t got;
    chan_status_t want;
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_bus.valid && rsp_bus.ready) begin
        got = '{rsp_bus.read_data, rsp_bus.wave_bit, rsp_bus.volume_level,
                rsp_bus.channel_active};
        if (expected_status.size() == 0) begin
          flag_mismatch(ALL_ZERO, got, 1'b1);
        end else begin
          want = expected_status.pop_front();
          if (got !== want) flag_mismatch(want, got, 1'b0);
        end
      end
      if (!hold_done && phase_num == 2 && rsp_bus.valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0] op;
    logic [2:0] ri;
    logic [7:0] wd;
    int         sel;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.opcode     = pcse_pkg::OP_READ;
    req_bus.reg_index  = pcse_pkg::REG_SWEEP;
    req_bus.write_data = 8'h00;

    sweep_fitted = 1'b1;
    {sweep_reg, len_duty_reg, env_reg, per_low_reg, per_high_reg} = '0;
    {div_count, duty_pos, wave_level, volume, env_ticks} = '0;
    {sweep_armed, sweep_countdown, shadow_freq, length_left} = '0;
    {sweep_overflow, len_gate_on, sweep_pace_held} = '0;

    directed_rows = '{
      '{pcse_pkg::OP_READ, pcse_pkg::REG_SWEEP, 8'h00, 1'b1, '{8'h00, 1'b0, 4'd0, 1'b0}},
      '{pcse_pkg::OP_READ, pcse_pkg::REG_PER_LOW, 8'h5A, 1'b1, '{8'hFF, 1'b0, 4'd0, 1'b0}},
      '{OP_SPARE6, pcse_pkg::REG_SWEEP, 8'hFF, 1'b1, ALL_ZERO},
      '{OP_SPARE7, REG_SPARE7, 8'h00, 1'b1, ALL_ZERO},
      '{pcse_pkg::OP_READ, REG_SPARE7, 8'h00, 1'b1, ALL_ZERO},
      '{pcse_pkg::OP_WRITE, REG_SPARE5, 8'hFF, 1'b1, ALL_ZERO},
      '{pcse_pkg::OP_WRITE, pcse_pkg::REG_ENVELOPE, 8'hF8, 1'b1, '{8'h00, 1'b0, 4'd0, 1'b1}},
      '{pcse_pkg::OP_READ, pcse_pkg::REG_ENVELOPE, 8'h00, 1'b1, '{8'hF8, 1'b0, 4'd0, 1'b1}},
      '{pcse_pkg::OP_WRITE, pcse_pkg::REG_LEN_DUTY, 8'hFF, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_READ, pcse_pkg::REG_LEN_DUTY, 8'h00, 1'b1, '{8'hC0, 1'b0, 4'd0, 1'b1}},
      '{pcse_pkg::OP_WRITE, pcse_pkg::REG_SWEEP, 8'h7F, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_READ, pcse_pkg::REG_SWEEP, 8'h00, 1'b1, '{8'h7F, 1'b0, 4'd0, 1'b1}},
      '{pcse_pkg::OP_WRITE, pcse_pkg::REG_PER_LOW, 8'hFF, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_WRITE, pcse_pkg::REG_PER_HIGH, 8'hC7, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_READ, pcse_pkg::REG_PER_HIGH, 8'h00, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_DIV_TICK, pcse_pkg::REG_SWEEP, 8'h00, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_ENV_TICK, pcse_pkg::REG_SWEEP, 8'h00, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_LEN_TICK, pcse_pkg::REG_SWEEP, 8'h00, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_LEN_TICK, pcse_pkg::REG_SWEEP, 8'h00, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_SWP_TICK, pcse_pkg::REG_SWEEP, 8'h00, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_WRITE, pcse_pkg::REG_ENVELOPE, 8'hF9, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_WRITE, pcse_pkg::REG_SWEEP, 8'h11, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_WRITE, pcse_pkg::REG_PER_HIGH, 8'h87, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_ENV_TICK, pcse_pkg::REG_SWEEP, 8'h00, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_WRITE, pcse_pkg::REG_ENVELOPE, 8'h01, 1'b0, ALL_ZERO},
      '{pcse_pkg::OP_ENV_TICK, pcse_pkg::REG_SWEEP, 8'h00, 1'b0, ALL_ZERO}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_sweep_present(1'b1);

    foreach (directed_rows[i]) begin
      send_event(directed_rows[i].op, directed_rows[i].ri, directed_rows[i].wd,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      write_sweep_present(ph != 0);
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 77 : 0;
      recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 12 : 0;
      phase_num = ph;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(99);
        ri  = 3'($urandom_range(7));
        wd  = 8'($urandom_range(255));
        if (sel < 26) begin
          op = pcse_pkg::OP_WRITE;
          if ($urandom_range(99) < 6) begin
            ri = 3'($urandom_range(REG_SPARE7, REG_SPARE5));
          end else begin
            ri = 3'($urandom_range(pcse_pkg::REG_PER_HIGH, pcse_pkg::REG_SWEEP));
          end
          case (ri)
            pcse_pkg::REG_ENVELOPE: begin
              if (wd[7:3] == 5'd0 && $urandom_range(9) != 0) wd[7] = 1'b1;
            end
            pcse_pkg::REG_PER_LOW: if ($urandom_range(1) != 0) wd[7:4] = 4'hF;
            pcse_pkg::REG_PER_HIGH: begin
              if ($urandom_range(3) != 0) wd[2:0] = 3'h7;
              if ($urandom_range(1) != 0) wd[7] = 1'b1;
            end
            default: ;
          endcase
        end else if (sel < 36) begin
          op = pcse_pkg::OP_READ;
        end else if (sel < 68) begin
          op = pcse_pkg::OP_DIV_TICK;
        end else if (sel < 80) begin
          op = pcse_pkg::OP_ENV_TICK;
        end else if (sel < 89) begin
          op = pcse_pkg::OP_LEN_TICK;
        end else if (sel < 97) begin
          op = pcse_pkg::OP_SWP_TICK;
        end else begin
          op = 3'($urandom_range(OP_SPARE7, OP_SPARE6));
        end
        send_event(op, ri, wd, 1'b0, ALL_ZERO);
      end
    end

    req_bus.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pcse_pkg.sv
rtl/core/pcse_req_if.sv
rtl/core/pcse_rsp_if.sv
rtl/core/pcse_datapath.sv
rtl/core/pcse_controller.sv
rtl/core/pulse_channel_sweep_envelope_top.sv
tb/sv/tb.sv
